@@ src/edn_pkg.sv @@
// shared types and codes for the edit distance nearest match block
package edn_pkg;

    localparam int SIM_W = 17;
    localparam int IDX_W = 16;
    localparam int DIST_W = 7;

    localparam logic [1:0] CMD_QUERY  = 2'd0;
    localparam logic [1:0] CMD_CAND   = 2'd1;
    localparam logic [1:0] CMD_EMPTY  = 2'd2;
    localparam logic [1:0] CMD_FINISH = 2'd3;

    localparam logic KIND_SCORE  = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] char_value;
        logic       last;
    } t_item;

endpackage

@@ src/edn_front.sv @@
// input side: accepts words and holds them in a two-entry queue
module edn_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  edn_pkg::t_item i_word,
    output logic          o_valid,
    output edn_pkg::t_item o_word,
    input  logic          i_pop
);
    edn_pkg::t_item r_mem [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;
    logic           push;
    logic           pop;

    assign o_stall = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_word  = r_mem[r_rp];
    assign push    = i_valid && !o_stall;
    assign pop     = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

@@ src/edn_div.sv @@
// restoring divider, one quotient bit per cycle
module edn_div #(
    parameter int NW = 23,
    parameter int DW = 7
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_done,
    output logic [NW-1:0] o_quot
);
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] r_num;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_den;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [DW:0]   trial;
    logic          ge;

    assign trial  = {r_rem, r_num[NW-1]};
    assign ge     = trial >= {1'b0, r_den};
    assign o_done = r_done;
    assign o_quot = r_num;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= ge ? DW'(trial - {1'b0, r_den}) : DW'(trial);
            r_num <= {r_num[NW-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end
endmodule

@@ src/edn_back.sv @@
// execution side: query store, cost row walk, scoring and best tracking
module edn_back #(
    parameter int MAX_LEN = 64,
    parameter int LW      = 7,
    parameter int QAW     = 6
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_item_valid,
    input  edn_pkg::t_item               i_item,
    output logic                         o_pop,
    input  logic [edn_pkg::SIM_W-1:0]    i_threshold,
    input  logic                         i_out_stall,
    output logic                         o_out_valid,
    output logic                         o_result_kind,
    output logic [edn_pkg::DIST_W-1:0]   o_edit_distance,
    output logic [edn_pkg::SIM_W-1:0]    o_similarity,
    output logic [edn_pkg::IDX_W-1:0]    o_candidate_index,
    output logic [edn_pkg::IDX_W-1:0]    o_best_index,
    output logic [edn_pkg::SIM_W-1:0]    o_top_similarity,
    output logic                         o_match_found,
    output logic                         o_truncated
);
    localparam int NW = LW + 16;
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RD    = 3'd1;
    localparam logic [2:0] S_CALC  = 3'd2;
    localparam logic [2:0] S_SCORE = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_PUT   = 3'd5;

    logic [7:0]    r_qmem [MAX_LEN];
    logic [LW-1:0] r_rmem [MAX_LEN];
    logic [7:0]    r_qrd;
    logic [LW-1:0] r_rrd;

    logic [2:0]    r_state;
    logic [2:0]    n_state;
    logic [LW-1:0] r_qlen;
    logic [LW-1:0] r_clen;
    logic [LW-1:0] r_pos;
    logic [LW-1:0] r_row0;
    logic [LW-1:0] r_left;
    logic [LW-1:0] r_corner;
    logic          r_first;
    logic [7:0]    r_ch;
    logic          r_last;
    logic          r_closed;
    logic          r_ovf;
    logic [edn_pkg::IDX_W-1:0] r_count;
    logic [edn_pkg::IDX_W-1:0] r_best_pos;
    logic [edn_pkg::SIM_W-1:0] r_best;
    logic [LW-1:0] r_dist;
    logic [LW-1:0] r_long;

    logic          r_ov;
    logic          r_o_kind;
    logic [LW-1:0] r_o_dist;
    logic [edn_pkg::SIM_W-1:0] r_o_sim;
    logic [edn_pkg::IDX_W-1:0] r_o_idx;
    logic [edn_pkg::IDX_W-1:0] r_o_bidx;
    logic [edn_pkg::SIM_W-1:0] r_o_bsim;
    logic          r_o_match;
    logic          r_o_trunc;

    logic          take;
    logic          out_free;
    logic          put_score;
    logic          put_report;
    logic [LW-1:0] upper;
    logic [LW-1:0] lo;
    logic [LW-1:0] cost_new;
    logic [LW-1:0] sc_dist;
    logic [LW-1:0] sc_long;
    logic          div_start;
    logic          div_done;
    logic [NW-1:0] div_q;
    logic [edn_pkg::SIM_W-1:0] sim;
    logic [QAW-1:0] rd_addr;

    assign out_free   = !r_ov || !i_out_stall;
    // a held result only blocks finish words here; a score waits for the output in S_PUT
    assign take       = (r_state == S_IDLE) && i_item_valid
                        && (i_item.command != edn_pkg::CMD_FINISH || out_free);
    assign put_report = take && (i_item.command == edn_pkg::CMD_FINISH);
    assign put_score  = (r_state == S_PUT) && out_free;
    assign o_pop      = take;
    assign rd_addr    = QAW'(r_pos - 1'b1);

    // cell update of the cost row
    always_comb begin
        upper = r_first ? r_pos : r_rrd;
        lo    = (upper < r_corner) ? upper : r_corner;
        if (r_left < lo) begin
            lo = r_left;
        end
        cost_new = (r_qrd == r_ch) ? r_corner : lo + 1'b1;
    end

    always_comb begin
        if (r_qlen == '0) begin
            sc_dist = r_clen;
        end else if (r_clen == '0) begin
            sc_dist = r_qlen;
        end else begin
            sc_dist = r_left;
        end
        sc_long = (r_qlen > r_clen) ? r_qlen : r_clen;
    end

    assign div_start = (r_state == S_SCORE);
    assign sim = (r_long == '0) ? '0 : div_q[edn_pkg::SIM_W-1:0];

    edn_div #(.NW(NW), .DW(LW)) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(div_start),
        .i_num  ({sc_long - sc_dist, 16'd0}),
        .i_den  (sc_long),
        .o_done (div_done),
        .o_quot (div_q)
    );

    always_ff @(posedge i_clk) begin
        if (take && i_item.command == edn_pkg::CMD_QUERY && !r_closed
            && r_qlen < LW'(MAX_LEN)) begin
            r_qmem[QAW'(r_qlen)] <= i_item.char_value;
        end else if (take && i_item.command == edn_pkg::CMD_QUERY && r_closed) begin
            r_qmem[QAW'(0)] <= i_item.char_value;
        end
        if (r_state == S_CALC) begin
            r_rmem[rd_addr] <= cost_new;
        end
        if (r_state == S_RD) begin
            r_qrd <= r_qmem[rd_addr];
            r_rrd <= r_rmem[rd_addr];
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (take) begin
                    unique case (i_item.command)
                        edn_pkg::CMD_QUERY:  n_state = S_IDLE;
                        edn_pkg::CMD_CAND: begin
                            if (r_clen < LW'(MAX_LEN) && r_qlen != '0) begin
                                n_state = S_RD;
                            end else if (i_item.last) begin
                                n_state = S_SCORE;
                            end
                        end
                        edn_pkg::CMD_EMPTY:  n_state = S_SCORE;
                        edn_pkg::CMD_FINISH: n_state = S_IDLE;
                        default:             n_state = S_IDLE;
                    endcase
                end
            end
            S_RD:   n_state = S_CALC;
            S_CALC: begin
                if (r_pos == r_qlen) begin
                    n_state = r_last ? S_SCORE : S_IDLE;
                end else begin
                    n_state = S_RD;
                end
            end
            S_SCORE: n_state = S_DIV;
            S_DIV:   n_state = div_done ? S_PUT : S_DIV;
            S_PUT:   n_state = out_free ? S_IDLE : S_PUT;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_qlen     <= '0;
            r_clen     <= '0;
            r_count    <= '0;
            r_best     <= '0;
            r_best_pos <= '0;
            r_ovf      <= 1'b0;
            r_closed   <= 1'b1;
            r_ov       <= 1'b0;
        end else begin
            r_state <= n_state;
            if (put_report || put_score) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
            if (take) begin
                r_ch   <= i_item.char_value;
                r_last <= i_item.last;
                if (i_item.command != edn_pkg::CMD_QUERY) begin
                    r_closed <= 1'b1;
                end
                unique case (i_item.command)
                    edn_pkg::CMD_QUERY: begin
                        r_closed <= 1'b0;
                        if (r_closed) begin
                            r_qlen     <= LW'(1);
                            r_clen     <= '0;
                            r_count    <= '0;
                            r_best     <= '0;
                            r_best_pos <= '0;
                            r_ovf      <= 1'b0;
                        end else if (r_qlen < LW'(MAX_LEN)) begin
                            r_qlen <= r_qlen + 1'b1;
                        end else begin
                            r_ovf <= 1'b1;
                        end
                    end
                    edn_pkg::CMD_CAND: begin
                        if (r_clen < LW'(MAX_LEN)) begin
                            // column zero of the new row is the candidate length
                            r_left   <= r_clen + 1'b1;
                            r_row0   <= r_clen + 1'b1;
                            r_corner <= (r_clen == '0) ? '0 : r_row0;
                            r_first  <= (r_clen == '0);
                            r_clen   <= r_clen + 1'b1;
                            r_pos    <= LW'(1);
                        end else begin
                            r_ovf <= 1'b1;
                        end
                    end
                    edn_pkg::CMD_EMPTY: begin
                        r_clen <= '0;
                    end
                    edn_pkg::CMD_FINISH: begin
                        r_clen    <= '0;
                        r_o_kind  <= edn_pkg::KIND_REPORT;
                        r_o_dist  <= '0;
                        r_o_sim   <= '0;
                        r_o_idx   <= r_count;
                        r_o_bidx  <= r_best_pos;
                        r_o_bsim  <= r_best;
                        r_o_match <= (r_qlen != '0) && (r_best > i_threshold);
                        r_o_trunc <= r_ovf;
                    end
                    default: ;
                endcase
            end
            if (r_state == S_CALC) begin
                r_left   <= cost_new;
                r_corner <= upper;
                r_pos    <= r_pos + 1'b1;
            end
            if (r_state == S_SCORE) begin
                r_dist <= sc_dist;
                r_long <= sc_long;
            end
            if (put_score) begin
                r_o_kind  <= edn_pkg::KIND_SCORE;
                r_o_dist  <= r_dist;
                r_o_sim   <= sim;
                r_o_idx   <= r_count;
                r_o_match <= 1'b0;
                r_o_trunc <= r_ovf;
                if (sim > r_best) begin
                    r_best     <= sim;
                    r_best_pos <= r_count;
                    r_o_bidx   <= r_count;
                    r_o_bsim   <= sim;
                end else begin
                    r_o_bidx <= r_best_pos;
                    r_o_bsim <= r_best;
                end
                r_count <= r_count + 1'b1;
                r_clen  <= '0;
            end
        end
    end

    assign o_out_valid       = r_ov;
    assign o_result_kind     = r_o_kind;
    assign o_edit_distance   = edn_pkg::DIST_W'(r_o_dist);
    assign o_similarity      = r_o_sim;
    assign o_candidate_index = r_o_idx;
    assign o_best_index      = r_o_bidx;
    assign o_top_similarity  = r_o_bsim;
    assign o_match_found     = r_o_match;
    assign o_truncated       = r_o_trunc;
endmodule

@@ src/edit_distance_nearest_match_top.sv @@
// top level of the edit distance nearest match block
// Query bytes are stored as they reach the back end. A candidate byte walks
// the cost row one query position at a time (memory read, then cell update).
// Closing a candidate adds a restoring divide (S_SCORE, S_DIV, then S_PUT). A
// result waits in an output register until taken; the back end keeps working
// behind it and only stops when it has a second result ready. A two-word queue
// in front lets input words arrive while the back end is busy.
module edit_distance_nearest_match_top #(
    parameter int MAX_LEN = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_command,
    input  logic [7:0]  i_char_value,
    input  logic        i_last,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_result_kind,
    output logic [6:0]  o_edit_distance,
    output logic [16:0] o_similarity,
    output logic [15:0] o_candidate_index,
    output logic [15:0] o_best_index,
    output logic [16:0] o_top_similarity,
    output logic        o_match_found,
    output logic        o_truncated,
    input  logic        i_cfg_we,
    input  logic [16:0] i_cfg_data
);
    localparam int LW  = $clog2(MAX_LEN + 1);
    localparam int QAW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

    logic [16:0]    r_threshold;
    edn_pkg::t_item in_word;
    edn_pkg::t_item q_word;
    logic           q_valid;
    logic           q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= '0;
        end else if (i_cfg_we) begin
            r_threshold <= i_cfg_data;
        end
    end

    assign in_word.command    = i_command;
    assign in_word.char_value = i_char_value;
    assign in_word.last       = i_last;

    edn_front u_front (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_in_valid),
        .o_stall(o_in_stall),
        .i_word (in_word),
        .o_valid(q_valid),
        .o_word (q_word),
        .i_pop  (q_pop)
    );

    edn_back #(.MAX_LEN(MAX_LEN), .LW(LW), .QAW(QAW)) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_item_valid     (q_valid),
        .i_item           (q_word),
        .o_pop            (q_pop),
        .i_threshold      (r_threshold),
        .i_out_stall      (i_out_stall),
        .o_out_valid      (o_out_valid),
        .o_result_kind    (o_result_kind),
        .o_edit_distance  (o_edit_distance),
        .o_similarity     (o_similarity),
        .o_candidate_index(o_candidate_index),
        .o_best_index     (o_best_index),
        .o_top_similarity (o_top_similarity),
        .o_match_found    (o_match_found),
        .o_truncated      (o_truncated)
    );

    a_report_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_result_kind == edn_pkg::KIND_REPORT
        |-> o_edit_distance == '0 && o_similarity == '0)
        else $error("report carries a distance or similarity");

    a_match_thr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_match_found |-> o_top_similarity > r_threshold)
        else $error("match flagged below threshold");

    a_score_best: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_result_kind == edn_pkg::KIND_SCORE
        |-> o_top_similarity >= o_similarity && !o_match_found)
        else $error("best similarity below current score");
endmodule

@@ dv/edn_match_checker.sv @@
// checker: predicts edit distance scores and best-match reports, compares outputs
`timescale 1ns / 1ps
module edn_match_checker #(
    parameter int MAX_LEN = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        o_in_stall,
    input  logic [1:0]  i_command,
    input  logic [7:0]  i_char_value,
    input  logic        i_last,
    input  logic        o_out_valid,
    input  logic        i_out_stall,
    input  logic        o_result_kind,
    input  logic [6:0]  o_edit_distance,
    input  logic [16:0] o_similarity,
    input  logic [15:0] o_candidate_index,
    input  logic [15:0] o_best_index,
    input  logic [16:0] o_top_similarity,
    input  logic        o_match_found,
    input  logic        o_truncated,
    input  logic        i_cfg_we,
    input  logic [16:0] i_cfg_data,
    output int          fail_count,
    output int          pending,
    output int          scores_seen,
    output int          reports_seen
);

    typedef struct {
        logic        kind;
        logic [6:0]  edist;
        logic [16:0] sim;
        logic [15:0] cand_idx;
        logic [15:0] best_idx;
        logic [16:0] best_sim;
        logic        match;
        logic        trunc;
    } t_score;

    logic [7:0]  query_mem [MAX_LEN];
    int          query_len;
    int          cost [MAX_LEN + 1];
    int          cand_len;
    logic [15:0] cand_count;
    logic [16:0] best_sim;
    logic [15:0] best_pos;
    logic        dropped;
    logic        query_done;
    logic [16:0] threshold;
    t_score      expected_scores [$];

    task automatic walk_cost_row(input logic [7:0] c);
        int corner;
        int upper;
        int v;
        corner = cost[0];
        cost[0] = cand_len + 1;
        for (int i = 1; i <= query_len; i++) begin
            upper = cost[i];
            if (query_mem[i - 1] == c) begin
                v = corner;
            end else begin
                v = (upper < corner) ? upper : corner;
                if (cost[i - 1] < v) v = cost[i - 1];
                v = v + 1;
            end
            cost[i] = v;
            corner = upper;
        end
    endtask

    task automatic score_candidate();
        int d;
        int longer;
        longint s;
        t_score e;
        longer = (query_len > cand_len) ? query_len : cand_len;
        if (query_len == 0) d = cand_len;
        else if (cand_len == 0) d = query_len;
        else d = cost[query_len];
        s = (longer == 0) ? 0 : ((longint'(longer - d) << 16) / longer);
        if (s > best_sim) begin
            best_sim = s[16:0];
            best_pos = cand_count;
        end
        e.kind = edn_pkg::KIND_SCORE;
        e.edist = d[6:0];
        e.sim = s[16:0];
        e.cand_idx = cand_count;
        e.best_idx = best_pos;
        e.best_sim = best_sim;
        e.match = 1'b0;
        e.trunc = dropped;
        expected_scores.insert(expected_scores.size(), e);
        cand_count = cand_count + 16'd1;
        cand_len = 0;
    endtask

    task automatic take_word(input logic [1:0] cmd, input logic [7:0] c, input logic lst);
        t_score e;
        if (cmd == edn_pkg::CMD_QUERY) begin
            if (query_done) begin
                query_done = 1'b0;
                query_len = 0;
                cand_len = 0;
                cand_count = '0;
                best_sim = '0;
                best_pos = '0;
                dropped = 1'b0;
            end
            if (query_len < MAX_LEN) begin
                query_mem[query_len] = c;
                query_len++;
            end else begin
                dropped = 1'b1;
            end
            return;
        end
        query_done = 1'b1;
        if (cmd == edn_pkg::CMD_CAND) begin
            if (cand_len == 0) begin
                for (int i = 0; i <= query_len; i++) cost[i] = i;
            end
            if (cand_len < MAX_LEN) begin
                walk_cost_row(c);
                cand_len++;
            end else begin
                dropped = 1'b1;
            end
            if (lst) score_candidate();
        end else if (cmd == edn_pkg::CMD_EMPTY) begin
            cand_len = 0;
            score_candidate();
        end else begin
            cand_len = 0;
            e.kind = edn_pkg::KIND_REPORT;
            e.edist = '0;
            e.sim = '0;
            e.cand_idx = cand_count;
            e.best_idx = best_pos;
            e.best_sim = best_sim;
            e.match = (query_len > 0) && (best_sim > threshold);
            e.trunc = dropped;
            expected_scores.insert(expected_scores.size(), e);
        end
    endtask

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_score e;
        if (!i_rst_n) begin
            fail_count = 0;
            scores_seen = 0;
            reports_seen = 0;
            query_len = 0;
            cand_len = 0;
            cand_count = '0;
            best_sim = '0;
            best_pos = '0;
            dropped = 1'b0;
            query_done = 1'b1;
            threshold = '0;
            expected_scores.delete();
        end else begin
            if (i_cfg_we) threshold = i_cfg_data;
            if (o_out_valid && !i_out_stall) begin
                if (expected_scores.size() == 0) begin
                    $error("result word with no expectation pending");
                    fail_count++;
                end else begin
                    e = expected_scores.pop_front();
                    if (e.kind == edn_pkg::KIND_REPORT) reports_seen++;
                    else scores_seen++;
                    check_field("result_kind", e.kind, o_result_kind);
                    check_field("edit_distance", e.edist, o_edit_distance);
                    check_field("similarity", e.sim, o_similarity);
                    check_field("candidate_index", e.cand_idx, o_candidate_index);
                    check_field("best_index", e.best_idx, o_best_index);
                    check_field("top_similarity", e.best_sim, o_top_similarity);
                    check_field("match_found", e.match, o_match_found);
                    check_field("truncated", e.trunc, o_truncated);
                end
            end
            if (i_in_valid && !o_in_stall) take_word(i_command, i_char_value, i_last);
        end
        pending = expected_scores.size();
    end

endmodule

@@ dv/tb.sv @@
// testbench top: drives query and candidate strings, idling, and gives the verdict
`timescale 1ns / 1ps
module tb;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 400;
    localparam int HOLD_CYCLES = 300;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [1:0]  i_command;
    logic [7:0]  i_char_value;
    logic        i_last;
    logic        o_out_valid;
    logic        i_out_stall;
    logic        o_result_kind;
    logic [6:0]  o_edit_distance;
    logic [16:0] o_similarity;
    logic [15:0] o_candidate_index;
    logic [15:0] o_best_index;
    logic [16:0] o_top_similarity;
    logic        o_match_found;
    logic        o_truncated;
    logic        i_cfg_we;
    logic [16:0] i_cfg_data;

    int fail_count;
    int pending;
    int scores_seen;
    int reports_seen;
    int words_sent;
    int sets_run;
    int send_idle_pct;
    int recv_idle_pct;
    bit hold_req;
    int quiet_cycles;
    logic [7:0] query_str [$];

    edit_distance_nearest_match_top uut (.*);

    edn_match_checker u_checker (.*);

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // receiver side, with one long hold-off on request
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic send_word(input logic [1:0] cmd, input logic [7:0] c, input logic lst);
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_command <= cmd;
        i_char_value <= c;
        i_last <= lst;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        words_sent++;
    endtask

    task automatic write_threshold(input logic [16:0] v);
        i_in_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [7:0] rand_char();
        if ($urandom_range(3) == 0) return 8'($urandom);
        return 8'h61 + 8'($urandom_range(3));
    endfunction

    function automatic int rand_len();
        if ($urandom_range(39) == 0) return $urandom_range(70, 60);
        return $urandom_range(8);
    endfunction

    // usually a new query, a few candidates near it, usually a finish
    task automatic run_set();
        int qn;
        int cn;
        logic [7:0] c;
        qn = rand_len();
        if ($urandom_range(19) == 0) qn = 0;
        if (qn > 0) query_str.delete();
        for (int i = 0; i < qn; i++) begin
            c = rand_char();
            query_str.insert(query_str.size(), c);
            send_word(edn_pkg::CMD_QUERY, c, 1'($urandom));
        end
        repeat ($urandom_range(5, 1)) begin
            if ($urandom_range(9) == 0) begin
                send_word(edn_pkg::CMD_EMPTY, 8'($urandom), 1'($urandom));
                continue;
            end
            cn = ($urandom_range(1)) ? query_str.size() : rand_len();
            if (cn == 0) cn = 1;
            // occasionally one or two extra random bytes that lead the candidate
            if ($urandom_range(14) == 0)
                send_word(edn_pkg::CMD_CAND, rand_char(), 1'b0);
            if ($urandom_range(29) == 0)
                send_word(edn_pkg::CMD_CAND, rand_char(), 1'b0);
            for (int i = 0; i < cn; i++) begin
                if (i < query_str.size() && $urandom_range(3) != 0) c = query_str[i];
                else c = rand_char();
                send_word(edn_pkg::CMD_CAND, c, i == cn - 1);
            end
        end
        if ($urandom_range(9) != 0)
            send_word(edn_pkg::CMD_FINISH, 8'($urandom), 1'($urandom));
        sets_run++;
    endtask

    task automatic random_phase(input int n, input int s_pct, input int r_pct);
        int stop_at;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        stop_at = words_sent + n;
        while (words_sent < stop_at) run_set();
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_command = edn_pkg::CMD_QUERY;
        i_char_value = '0;
        i_last = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        hold_req = 1'b0;
        words_sent = 0;
        sets_run = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_threshold(17'd0);
        // empty query: finish, empty candidate, one-byte candidate
        send_word(edn_pkg::CMD_FINISH, 8'h00, 1'b0);
        send_word(edn_pkg::CMD_EMPTY, 8'hFF, 1'b1);
        send_word(edn_pkg::CMD_CAND, 8'hFF, 1'b1);
        // query of extreme bytes, exact and partial matches
        send_word(edn_pkg::CMD_QUERY, 8'h00, 1'b0);
        send_word(edn_pkg::CMD_QUERY, 8'hFF, 1'b1);
        send_word(edn_pkg::CMD_CAND, 8'h00, 1'b0);
        send_word(edn_pkg::CMD_CAND, 8'hFF, 1'b1);
        send_word(edn_pkg::CMD_EMPTY, 8'h00, 1'b0);
        send_word(edn_pkg::CMD_CAND, 8'hFF, 1'b1);
        send_word(edn_pkg::CMD_CAND, 8'h55, 1'b0);
        send_word(edn_pkg::CMD_EMPTY, 8'hAA, 1'b0);
        send_word(edn_pkg::CMD_CAND, 8'hAA, 1'b0);
        send_word(edn_pkg::CMD_FINISH, 8'hFF, 1'b1);
        // set stays open after finish
        send_word(edn_pkg::CMD_CAND, 8'h00, 1'b1);
        send_word(edn_pkg::CMD_FINISH, 8'h00, 1'b0);
        query_str = '{8'h00, 8'hFF};

        write_threshold(17'd65536);
        random_phase(400, 11, 52);
        write_threshold(17'($urandom_range(65535, 1)));
        random_phase(400, 52, 11);
        write_threshold(17'd65535);
        hold_req = 1'b1;
        random_phase(400, 0, 0);

        i_in_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("run covered %0d input words in %0d query sets", words_sent, sets_run);
        $display("checked %0d candidate scores and %0d best-match reports",
                 scores_seen, reports_seen);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

@@ files.f @@
src/edn_pkg.sv
src/edn_front.sv
src/edn_div.sv
src/edn_back.sv
src/edit_distance_nearest_match_top.sv
dv/edn_match_checker.sv
dv/tb.sv
